>>> src/b64d_pkg.sv
// Shared types, status codes and the character classifier for the base64 decoder.
// Depends on nothing; the front, queue, back and top modules import it.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_EARLY_PAD = 3'd2;
  localparam logic [2:0] ST_AFTER_PAD = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued job for the back end: a decoded group or a closing error.
  typedef struct packed {
    logic [23:0] group;    // three bytes, oldest highest; zero for an error
    logic [1:0]  count;    // number of results, 1 to 3
    logic [2:0]  status;
    logic        done;     // last result of this job closes the message
  } b64d_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
    b64d_sextet_t r;
    logic [7:0]   t;
    r = '0;
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

>>> src/base64_stream_decoder_core.sv
// Base64 stream decoder top level: front end, job queue, back end.
// Throughput: one character accepted per cycle while the queue has room; one result leaves
// per cycle while the sink is ready, so a full group gives three results in all.
// A group's job is queued with its last character and offered once it heads the queue.
// Reset (rst, synchronous, active high) clears group state, error state and the queue.
module base64_stream_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [2:0] status,
  output logic       message_done,
  output logic       run_end
);
  import b64d_pkg::*;

  logic        in_take;
  logic        push;
  logic        pop;
  b64d_entry_t job;
  b64d_entry_t head;
  b64d_qstat_t qstat;

  // Accept whenever the queue can take a job; a character that causes no
  // result simply advances the front-end state.
  assign in_ready = !qstat.full;
  assign in_take  = in_valid && in_ready;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (in_take),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .push        (push),
    .job         (job)
  );

  // The queue parts the two sides: hold finished jobs while the sink stalls.
  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (job),
    .pop      (pop),
    .rd_entry (head),
    .stat     (qstat)
  );

  assign out_valid = !qstat.empty;

  // Drain the head job one transaction at a time; drop it after its last result.
  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .have_job     (out_valid),
    .take         (out_ready),
    .pop          (pop),
    .data_byte    (data_byte),
    .status       (status),
    .message_done (message_done),
    .run_end      (run_end)
  );

endmodule

>>> src/b64d_front.sv
// Front end: classify each character, track group state and errors,
// and produce one queue job when a character causes results. Uses b64d_pkg.
module b64d_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           symbol,
  input  logic                 end_of_text,
  output logic                 push,
  output b64d_pkg::b64d_entry_t job
);
  import b64d_pkg::*;

  logic [1:0]   slot_count, slot_count_next;
  logic [17:0]  sextet_store, sextet_store_next;
  logic [1:0]   pad_count, pad_count_next;
  logic         padded_group_seen, padded_group_seen_next;
  logic [2:0]   error_code, error_code_next;
  logic [5:0]   v;
  logic         emit;
  b64d_sextet_t dec;

  assign dec = sextet_of(symbol);

  always_comb begin
    slot_count_next        = slot_count;
    sextet_store_next      = sextet_store;
    pad_count_next         = pad_count;
    padded_group_seen_next = padded_group_seen;
    error_code_next        = error_code;
    v                      = '0;
    emit                   = 1'b0;
    job                    = '0;
    if (error_code == ST_OK) begin
      if (padded_group_seen) begin
        error_code_next = ST_AFTER_PAD;
      end else if (symbol == PAD_CHAR) begin
        if (slot_count < 2'd2) error_code_next = ST_EARLY_PAD;
        else pad_count_next = pad_count + 2'd1;
      end else if (!dec.valid) begin
        error_code_next = ST_BAD_CHAR;
      end else if (pad_count != 2'd0) begin
        error_code_next = ST_AFTER_PAD;
      end else begin
        v = dec.value;
      end
      if (error_code_next == ST_OK) begin
        if (slot_count != 2'd3) begin
          sextet_store_next = {sextet_store[11:0], v};
          slot_count_next   = slot_count + 2'd1;
          if (end_of_text) error_code_next = ST_BAD_LEN;
        end else begin
          emit                   = 1'b1;
          job.group              = {sextet_store, v};
          job.count              = 2'd3 - pad_count_next;
          job.status             = ST_OK;
          job.done               = end_of_text;
          padded_group_seen_next = (pad_count_next != 2'd0);
          slot_count_next        = '0;
          sextet_store_next      = '0;
          pad_count_next         = '0;
        end
      end
    end
    if (end_of_text) begin
      if (error_code_next != ST_OK) begin
        emit       = 1'b1;
        job.group  = '0;
        job.count  = 2'd1;
        job.status = error_code_next;
        job.done   = 1'b1;
      end
      slot_count_next        = '0;
      sextet_store_next      = '0;
      pad_count_next         = '0;
      padded_group_seen_next = 1'b0;
      error_code_next        = ST_OK;
    end
  end

  assign push = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count        <= '0;
      sextet_store      <= '0;
      pad_count         <= '0;
      padded_group_seen <= 1'b0;
      error_code        <= ST_OK;
    end else if (take) begin
      slot_count        <= slot_count_next;
      sextet_store      <= sextet_store_next;
      pad_count         <= pad_count_next;
      padded_group_seen <= padded_group_seen_next;
      error_code        <= error_code_next;
    end
  end

endmodule

>>> src/b64d_queue.sv
// Short job queue between the front and back ends.
// Uses b64d_pkg for the entry type and depth.
module b64d_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64d_pkg::b64d_entry_t wr_entry,
  input  logic                  pop,
  output b64d_pkg::b64d_entry_t rd_entry,
  output b64d_pkg::b64d_qstat_t stat
);
  import b64d_pkg::*;

  b64d_entry_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_entry   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> src/b64d_back.sv
// Back end: step through the head job of the queue, one result per transaction.
// Uses b64d_pkg for the entry type.
module b64d_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64d_pkg::b64d_entry_t head,
  input  logic                  have_job,
  input  logic                  take,
  output logic                  pop,
  output logic [7:0]            data_byte,
  output logic [2:0]            status,
  output logic                  message_done,
  output logic                  run_end
);
  import b64d_pkg::*;

  logic [1:0] idx;

  always_comb begin
    unique case (idx)
      2'd0:    data_byte = head.group[23:16];
      2'd1:    data_byte = head.group[15:8];
      default: data_byte = head.group[7:0];
    endcase
  end

  assign status       = head.status;
  assign run_end      = (idx == head.count - 2'd1);
  assign message_done = run_end && head.done;
  assign pop          = have_job && take && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (have_job && take) begin
      idx <= run_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
